/* hdl/altitude_inertial_filter_assert.svh */
// assertion macros for the altitude filter
`ifndef ALTITUDE_INERTIAL_FILTER_ASSERT_SVH
`define ALTITUDE_INERTIAL_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AIF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define AIF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/aif_pkg.sv */
package aif_pkg;

   // sequencer sizes
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 49;
   localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);
   localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

   // divider constants
   localparam logic [19:0] DT_DIVISOR    = 20'd1000000;
   localparam logic [19:0] THIRD_DIVISOR = 20'd6;
   localparam logic [48:0] DT_ROUND      = 49'd500000;
   localparam logic [36:0] THIRD_BIAS    = 37'd51539607552;
   localparam logic signed [63:0] THIRD_OFFSET = 64'sd8589934592;

   // fixed point limits
   localparam logic signed [31:0] Q_MAX  = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
   localparam logic signed [31:0] Q_HALF = 32'sd32768;
   localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

   // register defaults
   localparam logic [23:0] ALT_WEIGHT_RST   = 24'd32768;
   localparam logic [23:0] ACCEL_WEIGHT_RST = 24'd1310720;
   localparam logic [23:0] BIAS_WEIGHT_RST  = 24'd3277;
   localparam logic [19:0] GRAVITY_RST      = 20'd642689;

   typedef enum logic [1:0] {
      CSR_ALT_WEIGHT   = 2'd0,
      CSR_ACCEL_WEIGHT = 2'd1,
      CSR_BIAS_WEIGHT  = 2'd2,
      CSR_GRAVITY      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_MUL, KIND_ALU, KIND_DIVDT, KIND_DIV3, KIND_END
   } kind_type;

   typedef enum logic [3:0] {
      ALU_NONE, ALU_ALTERR, ALU_DIFF0, ALU_DIFF1, ALU_DIFF2,
      ALU_ACCRND, ALU_ACCERR, ALU_NEGB2, ALU_PRED, ALU_X0E
   } alu_type;

   typedef enum logic [3:0] {
      SRC_ALTERR, SRC_ACCERR, SRC_WA, SRC_WB, SRC_WC, SRC_DT, SRC_HALF, SRC_CORR,
      SRC_T0, SRC_T1, SRC_T3, SRC_X1, SRC_X2, SRC_ROT0, SRC_ROT1, SRC_ROT2
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_T0, DST_T1, DST_T2, DST_T3, DST_CORR, DST_BIAS0, DST_BIAS1,
      DST_BIAS2, DST_X1ADD, DST_X2ADD, DST_MACC
   } dst_type;

   typedef struct packed {
      kind_type kind;
      alu_type  alu;
      src_type  src_a;
      src_type  src_b;
      dst_type  dst;
      logic     fresh_only;
   } uop_type;

   function automatic logic signed [63:0] ext32(input logic [31:0] v);
      return $signed({{32{v[31]}}, v});
   endfunction

   function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
      if (v > Q_MAX64) return Q_MAX;
      if (v < Q_MIN64) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      if (v == Q_MIN) return Q_MAX;
      return -v;
   endfunction

   // product back to q16.16: add half lsb, floor, saturate
   function automatic logic signed [31:0] round_q(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd32768;
      return sat_q(s >>> 16);
   endfunction

   function automatic uop_type mul_op(input src_type a, input src_type b,
                                      input dst_type d, input logic f);
      uop_type u;
      u.kind = KIND_MUL;
      u.alu = ALU_NONE;
      u.src_a = a;
      u.src_b = b;
      u.dst = d;
      u.fresh_only = f;
      return u;
   endfunction

   function automatic uop_type alu_op(input alu_type op, input logic f);
      uop_type u;
      u.kind = KIND_ALU;
      u.alu = op;
      u.src_a = SRC_T0;
      u.src_b = SRC_T0;
      u.dst = DST_NONE;
      u.fresh_only = f;
      return u;
   endfunction

   function automatic uop_type misc_op(input kind_type k);
      uop_type u;
      u.kind = k;
      u.alu = ALU_NONE;
      u.src_a = SRC_T0;
      u.src_b = SRC_T0;
      u.dst = DST_NONE;
      u.fresh_only = 1'b0;
      return u;
   endfunction

   // filter microprogram
   function automatic uop_type uop_rom(input logic [5:0] pc);
      case (pc)
         6'd0:  return misc_op(KIND_DIVDT);
         6'd1:  return alu_op(ALU_ALTERR, 1'b1);
         6'd2:  return alu_op(ALU_DIFF0, 1'b1);
         6'd3:  return mul_op(SRC_T0, SRC_ROT0, DST_MACC, 1'b1);
         6'd4:  return alu_op(ALU_DIFF1, 1'b1);
         6'd5:  return mul_op(SRC_T0, SRC_ROT1, DST_MACC, 1'b1);
         6'd6:  return alu_op(ALU_DIFF2, 1'b1);
         6'd7:  return mul_op(SRC_T0, SRC_ROT2, DST_MACC, 1'b1);
         6'd8:  return alu_op(ALU_ACCRND, 1'b1);
         6'd9:  return alu_op(ALU_ACCERR, 1'b1);
         6'd10: return mul_op(SRC_ALTERR, SRC_WA, DST_T0, 1'b0);
         6'd11: return mul_op(SRC_T0, SRC_WA, DST_CORR, 1'b0);
         6'd12: return mul_op(SRC_ROT0, SRC_CORR, DST_T0, 1'b0);
         6'd13: return mul_op(SRC_T0, SRC_WB, DST_T0, 1'b0);
         6'd14: return mul_op(SRC_T0, SRC_DT, DST_BIAS0, 1'b0);
         6'd15: return mul_op(SRC_ROT1, SRC_CORR, DST_T0, 1'b0);
         6'd16: return mul_op(SRC_T0, SRC_WB, DST_T0, 1'b0);
         6'd17: return mul_op(SRC_T0, SRC_DT, DST_BIAS1, 1'b0);
         6'd18: return mul_op(SRC_ROT2, SRC_CORR, DST_T0, 1'b0);
         6'd19: return mul_op(SRC_T0, SRC_WB, DST_T0, 1'b0);
         6'd20: return mul_op(SRC_T0, SRC_DT, DST_BIAS2, 1'b0);
         6'd21: return alu_op(ALU_NEGB2, 1'b0);
         6'd22: return mul_op(SRC_X2, SRC_DT, DST_T1, 1'b0);
         6'd23: return mul_op(SRC_T1, SRC_DT, DST_T0, 1'b0);
         6'd24: return mul_op(SRC_T0, SRC_HALF, DST_T2, 1'b0);
         6'd25: return mul_op(SRC_X1, SRC_DT, DST_T0, 1'b0);
         6'd26: return alu_op(ALU_PRED, 1'b0);
         6'd27: return mul_op(SRC_ALTERR, SRC_WA, DST_T0, 1'b0);
         6'd28: return mul_op(SRC_T0, SRC_DT, DST_T3, 1'b0);
         6'd29: return alu_op(ALU_X0E, 1'b0);
         6'd30: return mul_op(SRC_WA, SRC_T3, DST_X1ADD, 1'b0);
         6'd31: return mul_op(SRC_WA, SRC_WA, DST_T0, 1'b0);
         6'd32: return mul_op(SRC_T0, SRC_T3, DST_T0, 1'b0);
         6'd33: return misc_op(KIND_DIV3);
         6'd34: return mul_op(SRC_ACCERR, SRC_WC, DST_T0, 1'b0);
         6'd35: return mul_op(SRC_T0, SRC_DT, DST_X2ADD, 1'b0);
         default: return misc_op(KIND_END);
      endcase
   endfunction

endpackage

/* hdl/altitude_inertial_filter.sv */
// channel   ports                       direction
// req       req_valid / req_stall       input words, time stamp, sensors, rotation column
// rsp       rsp_valid / rsp_stall       output words, down position, velocity, acceleration
// csr       csr_wr_en                   gain and gravity register writes
//
// an item runs from accept to result through the one shared bit-serial multiplier (22 products
// without fresh sensor data, 25 with it) and the bit-serial divider (used for dt and for the third).
// reset is synchronous: estimate, errors, bias and time stamp go to zero, gains and gravity to defaults.
// req_stall stays high from accept until the result word is loaded into the output register.
// a new word is taken while a result waits on rsp_stall; the sequencer holds at its end
// until the output register is free.
`include "altitude_inertial_filter_assert.svh"

module altitude_inertial_filter import aif_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_time_us,
   input  logic               req_sensor_fresh,
   input  logic               req_use_ultrasonic,
   input  logic signed [31:0] req_baro_alt,
   input  logic signed [31:0] req_ultra_height,
   input  logic signed [31:0] req_accel_x,
   input  logic signed [31:0] req_accel_y,
   input  logic signed [31:0] req_accel_z,
   input  logic signed [17:0] req_rot_x,
   input  logic signed [17:0] req_rot_y,
   input  logic signed [17:0] req_rot_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_est_alt,
   output logic signed [31:0] rsp_est_vel,
   output logic signed [31:0] rsp_est_acc,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_RND   = 7'b0001000,
      ST_WB    = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DIVWB = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic [5:0] cnt_ff, cnt_in;

   // configuration
   logic [23:0] alt_w_ff, alt_w_in;
   logic [23:0] acc_w_ff, acc_w_in;
   logic [23:0] bias_w_ff, bias_w_in;
   logic [19:0] gravity_ff, gravity_in;

   // latched item
   logic [31:0] now_ff, now_in;
   logic fresh_ff, fresh_in;
   logic signed [31:0] alt_ff, alt_in;
   logic signed [31:0] acc0_ff, acc0_in, acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [17:0] rot0_ff, rot0_in, rot1_ff, rot1_in, rot2_ff, rot2_in;

   // filter state
   logic [31:0] prev_time_ff, prev_time_in;
   logic signed [31:0] est0_ff, est0_in, est1_ff, est1_in, est2_ff, est2_in;
   logic signed [31:0] alt_err_ff, alt_err_in, acc_err_ff, acc_err_in;
   logic signed [31:0] bias0_ff, bias0_in, bias1_ff, bias1_in, bias2_ff, bias2_in;

   // working values
   logic signed [31:0] dt_ff, dt_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [31:0] corr_ff, corr_in;
   logic signed [50:0] sum_ff, sum_in;
   logic signed [31:0] r_ff, r_in;

   // bit-serial multiplier
   logic [31:0] mc_ff, mc_in;
   logic [31:0] mp_ff, mp_in;
   logic [32:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;

   // bit-serial divider
   logic [48:0] dvd_ff, dvd_in;
   logic [19:0] rem_ff, rem_in;
   logic div3_ff, div3_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_alt_ff, out_alt_in, out_vel_ff, out_vel_in;
   logic signed [31:0] out_acc_ff, out_acc_in;

   uop_type uop;
   logic req_accept, rsp_take;
   logic [32:0] mul_add, hi_sum;
   logic signed [63:0] prod;
   logic [19:0] divisor;
   logic [20:0] div_shift;
   logic [21:0] div_trial;
   logic [31:0] time_diff;
   logic [36:0] third_num;
   logic signed [63:0] sum64;

   function automatic logic [31:0] pick_src(input src_type s);
      case (s)
         SRC_ALTERR: return alt_err_ff;
         SRC_ACCERR: return acc_err_ff;
         SRC_WA:     return {8'd0, alt_w_ff};
         SRC_WB:     return {8'd0, bias_w_ff};
         SRC_WC:     return {8'd0, acc_w_ff};
         SRC_DT:     return dt_ff;
         SRC_HALF:   return Q_HALF;
         SRC_CORR:   return corr_ff;
         SRC_T0:     return t0_ff;
         SRC_T1:     return t1_ff;
         SRC_T3:     return t3_ff;
         SRC_X1:     return est1_ff;
         SRC_X2:     return est2_ff;
         SRC_ROT0:   return {{14{rot0_ff[17]}}, rot0_ff};
         SRC_ROT1:   return {{14{rot1_ff[17]}}, rot1_ff};
         SRC_ROT2:   return {{14{rot2_ff[17]}}, rot2_ff};
         default:    return '0;
      endcase
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_est_alt = out_alt_ff;
   assign rsp_est_vel = out_vel_ff;
   assign rsp_est_acc = out_acc_ff;

   assign uop = uop_rom(pc_ff);

   // one multiplier bit a cycle, the top bit carries negative weight
   assign mul_add = {mc_ff[31], mc_ff};
   always_comb begin
      if (!mp_ff[0]) begin
         hi_sum = hi_ff;
      end else if (cnt_ff == MUL_LAST) begin
         hi_sum = hi_ff - mul_add;
      end else begin
         hi_sum = hi_ff + mul_add;
      end
   end
   assign prod = $signed({hi_ff[31:0], lo_ff});

   // one quotient bit a cycle, restoring
   assign divisor   = div3_ff ? THIRD_DIVISOR : DT_DIVISOR;
   assign div_shift = {rem_ff, dvd_ff[48]};
   assign div_trial = {1'b0, div_shift} - {2'b00, divisor};

   assign time_diff = now_ff - prev_time_ff;
   // 2t + 3, lifted by six times 2^33 to stay non-negative
   assign third_num = {{4{t0_ff[31]}}, t0_ff, 1'b0} + 37'd3 + THIRD_BIAS;
   assign sum64 = $signed({{13{sum_ff[50]}}, sum_ff});

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      cnt_in = cnt_ff;
      alt_w_in = alt_w_ff;
      acc_w_in = acc_w_ff;
      bias_w_in = bias_w_ff;
      gravity_in = gravity_ff;
      now_in = now_ff;
      fresh_in = fresh_ff;
      alt_in = alt_ff;
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      rot0_in = rot0_ff;
      rot1_in = rot1_ff;
      rot2_in = rot2_ff;
      prev_time_in = prev_time_ff;
      est0_in = est0_ff;
      est1_in = est1_ff;
      est2_in = est2_ff;
      alt_err_in = alt_err_ff;
      acc_err_in = acc_err_ff;
      bias0_in = bias0_ff;
      bias1_in = bias1_ff;
      bias2_in = bias2_ff;
      dt_in = dt_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      corr_in = corr_ff;
      sum_in = sum_ff;
      r_in = r_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      div3_in = div3_ff;
      rsp_valid_in = rsp_valid_ff;
      out_alt_in = out_alt_ff;
      out_vel_in = out_vel_ff;
      out_acc_in = out_acc_ff;

      // output word leaves
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ALT_WEIGHT:   alt_w_in = csr_wdata;
            CSR_ACCEL_WEIGHT: acc_w_in = csr_wdata;
            CSR_BIAS_WEIGHT:  bias_w_in = csr_wdata;
            CSR_GRAVITY:      gravity_in = csr_wdata[19:0];
            default:          alt_w_in = alt_w_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               now_in = req_time_us;
               fresh_in = req_sensor_fresh;
               alt_in = req_use_ultrasonic ? req_ultra_height : req_baro_alt;
               acc0_in = req_accel_x;
               acc1_in = req_accel_y;
               acc2_in = req_accel_z;
               rot0_in = req_rot_x;
               rot1_in = req_rot_y;
               rot2_in = req_rot_z;
               pc_in = '0;
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            if (uop.fresh_only && !fresh_ff) begin
               pc_in = pc_ff + 6'd1;
            end else begin
               case (uop.kind)
                  KIND_MUL: begin
                     mc_in = pick_src(uop.src_a);
                     mp_in = pick_src(uop.src_b);
                     hi_in = '0;
                     lo_in = '0;
                     cnt_in = '0;
                     state_in = ST_MUL;
                  end
                  KIND_DIVDT: begin
                     prev_time_in = now_ff;
                     if (prev_time_ff != 32'd0) begin
                        dvd_in = {1'b0, time_diff, 16'd0} + DT_ROUND;
                     end else begin
                        dvd_in = '0;
                     end
                     rem_in = '0;
                     div3_in = 1'b0;
                     cnt_in = '0;
                     state_in = ST_DIV;
                  end
                  KIND_DIV3: begin
                     dvd_in = {12'd0, third_num};
                     rem_in = '0;
                     div3_in = 1'b1;
                     cnt_in = '0;
                     state_in = ST_DIV;
                  end
                  KIND_ALU: begin
                     case (uop.alu)
                        ALU_ALTERR: begin
                           alt_err_in = sat_q(-ext32(alt_ff) - ext32(est0_ff));
                           sum_in = '0;
                        end
                        ALU_DIFF0: t0_in = sat_q(ext32(acc0_ff) - ext32(bias0_ff));
                        ALU_DIFF1: t0_in = sat_q(ext32(acc1_ff) - ext32(bias1_ff));
                        ALU_DIFF2: t0_in = sat_q(ext32(acc2_ff) - ext32(bias2_ff));
                        ALU_ACCRND: t0_in = round_q(sum64);
                        ALU_ACCERR: begin
                           acc_err_in = sat_q(ext32(neg_sat(t0_ff)) + ext32({12'd0, gravity_ff})
                                              - ext32(est2_ff));
                        end
                        ALU_NEGB2: bias2_in = neg_sat(bias2_ff);
                        ALU_PRED: begin
                           est0_in = sat_q(ext32(est0_ff) + ext32(t0_ff) + ext32(t2_ff));
                           est1_in = sat_q(ext32(est1_ff) + ext32(t1_ff));
                        end
                        ALU_X0E: est0_in = sat_q(ext32(est0_ff) + ext32(t3_ff));
                        default: t0_in = t0_ff;
                     endcase
                     pc_in = pc_ff + 6'd1;
                  end
                  KIND_END: begin
                     if (!rsp_valid_ff || rsp_take) begin
                        rsp_valid_in = 1'b1;
                        out_alt_in = est0_ff;
                        out_vel_in = est1_ff;
                        out_acc_in = est2_ff;
                        state_in = ST_IDLE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // shift-add, low product bits fall into lo
         ST_MUL: begin
            hi_in = {hi_sum[32], hi_sum[32:1]};
            lo_in = {hi_sum[0], lo_ff[31:1]};
            mp_in = {1'b0, mp_ff[31:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_RND;
            end
         end

         ST_RND: begin
            r_in = round_q(prod);
            state_in = ST_WB;
         end

         // write the product to its place
         ST_WB: begin
            case (uop.dst)
               DST_T0:    t0_in = r_ff;
               DST_T1:    t1_in = r_ff;
               DST_T2:    t2_in = r_ff;
               DST_T3:    t3_in = r_ff;
               DST_CORR:  corr_in = neg_sat(r_ff);
               DST_BIAS0: bias0_in = sat_q(ext32(bias0_ff) + ext32(r_ff));
               DST_BIAS1: bias1_in = sat_q(ext32(bias1_ff) + ext32(r_ff));
               DST_BIAS2: bias2_in = sat_q(ext32(bias2_ff) + ext32(r_ff));
               DST_X1ADD: est1_in = sat_q(ext32(est1_ff) + ext32(r_ff));
               DST_X2ADD: est2_in = sat_q(ext32(est2_ff) + ext32(r_ff));
               DST_MACC:  sum_in = sum_ff + prod[50:0];
               default:   t0_in = t0_ff;
            endcase
            pc_in = pc_ff + 6'd1;
            state_in = ST_FETCH;
         end

         ST_DIV: begin
            if (!div_trial[21]) begin
               rem_in = div_trial[19:0];
            end else begin
               rem_in = div_shift[19:0];
            end
            dvd_in = {dvd_ff[47:0], !div_trial[21]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIVWB;
            end
         end

         ST_DIVWB: begin
            if (div3_ff) begin
               est2_in = sat_q(ext32(est2_ff) + $signed({15'd0, dvd_ff}) - THIRD_OFFSET);
            end else begin
               dt_in = dvd_ff[31:0];
            end
            pc_in = pc_ff + 6'd1;
            state_in = ST_FETCH;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         alt_w_ff <= ALT_WEIGHT_RST;
         acc_w_ff <= ACCEL_WEIGHT_RST;
         bias_w_ff <= BIAS_WEIGHT_RST;
         gravity_ff <= GRAVITY_RST;
         prev_time_ff <= '0;
         est0_ff <= '0;
         est1_ff <= '0;
         est2_ff <= '0;
         alt_err_ff <= '0;
         acc_err_ff <= '0;
         bias0_ff <= '0;
         bias1_ff <= '0;
         bias2_ff <= '0;
         div3_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         alt_w_ff <= alt_w_in;
         acc_w_ff <= acc_w_in;
         bias_w_ff <= bias_w_in;
         gravity_ff <= gravity_in;
         prev_time_ff <= prev_time_in;
         est0_ff <= est0_in;
         est1_ff <= est1_in;
         est2_ff <= est2_in;
         alt_err_ff <= alt_err_in;
         acc_err_ff <= acc_err_in;
         bias0_ff <= bias0_in;
         bias1_ff <= bias1_in;
         bias2_ff <= bias2_in;
         div3_ff <= div3_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      now_ff <= now_in;
      fresh_ff <= fresh_in;
      alt_ff <= alt_in;
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      rot0_ff <= rot0_in;
      rot1_ff <= rot1_in;
      rot2_ff <= rot2_in;
      dt_ff <= dt_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      corr_ff <= corr_in;
      sum_ff <= sum_in;
      r_ff <= r_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      out_alt_ff <= out_alt_in;
      out_vel_ff <= out_vel_in;
      out_acc_ff <= out_acc_in;
   end

   // checks
   `AIF_ASSERT_IMP(a_mul_count, state_ff == ST_MUL, cnt_ff <= MUL_LAST, "multiplier overran")
   `AIF_ASSERT_IMP(a_div_count, state_ff == ST_DIV, cnt_ff <= DIV_LAST, "divider overran")
   `AIF_ASSERT_NXT(a_accept_start, req_accept, state_ff == ST_FETCH && pc_ff == 6'd0, "bad start")
   `AIF_ASSERT_NXT(a_dt_range, state_ff == ST_DIVWB && !div3_ff, dt_ff[31:29] == 3'd0, "dt range")

endmodule
